// ----- design/rc4d_pkg.sv -----
package rc4d_pkg;

  // Field and table sizes
  localparam int BYTE_W            = 8;
  localparam int PERM_DEPTH        = 256;
  localparam int PERM_AW           = $clog2(PERM_DEPTH);
  localparam int MAX_KEY_BYTES_DEF = 256;

  // Configuration port
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 3;
  localparam int PASSES_W = 8;
  localparam int DROP_W   = 16;

  localparam logic [PASSES_W-1:0] PASSES_RST = 8'd1;
  localparam logic [DROP_W-1:0]   DROP_RST   = 16'd0;

  // Register select, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_PASSES = 1'b0,
    REG_DROP   = 1'b1
  } reg_idx_t;

  // Input word kinds
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_SW,
    ST_KS_W1,
    ST_KS_W2,
    ST_GEN_RD,
    ST_GEN_SW,
    ST_GEN_W1,
    ST_GEN_W2
  } state_t;

  // Write request into the permutation RAM
  typedef struct packed {
    logic               en;
    logic [PERM_AW-1:0] addr;
    logic [BYTE_W-1:0]  data;
  } perm_wr_t;

endpackage

// ----- design/rc4d_perm_ram.sv -----
module rc4d_perm_ram (
  input  logic                                 clk,
  input  rc4d_pkg::perm_wr_t                   wr,
  input  logic [rc4d_pkg::PERM_AW-1:0]         rd_addr,
  output logic [rc4d_pkg::BYTE_W-1:0]          rd_data
);
  import rc4d_pkg::*;

  logic [BYTE_W-1:0] mem [PERM_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  // One write port, one registered read port (read returns old data on collision)
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/rc4_drop_stream_cipher_core.sv -----
// RC4-drop stream cipher core, but its keystream byte is S[i] + S[j] after the swap.
// Key bytes (in_kind = 0) are taken one per cycle while idle and stored; the key byte
// flagged with in_key_last starts the key schedule, which fills the permutation with
// the identity, runs passes_r passes of 256 swap steps (ST_KS_RD, ST_KS_SW, ST_KS_W1,
// ST_KS_W2) and then discards drop_r keystream bytes, with in_ready low until done.
// Each data byte (in_kind = 1) holds in_ready low through ST_GEN_RD, ST_GEN_SW,
// ST_GEN_W1 and ST_GEN_W2, so no new byte is taken before it is through; its out_byte
// = data XOR keystream is registered in ST_GEN_W2. Every step is bound by the single
// read and single write port of the 256 x 8 permutation RAM. A finished word waits
// in the output register while the next item is taken; the next data byte then stalls
// in its last step until that word leaves. The schedule reads passes_r as it runs and
// drop_r at its end; data sent before any key gives an unspecified result.
module rc4_drop_stream_cipher_core #(
  parameter int MAX_KEY_BYTES = rc4d_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [rc4d_pkg::BYTE_W-1:0]   in_value,
  input  logic                          in_key_last,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rc4d_pkg::BYTE_W-1:0]   out_byte,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rc4d_pkg::CFG_AW-1:0]   paddr,
  input  logic [rc4d_pkg::CFG_DW-1:0]   pwdata,
  output logic [rc4d_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import rc4d_pkg::*;

  localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KLW-1:0]     MAX_LEN  = KLW'(MAX_KEY_BYTES);
  localparam logic [PERM_AW-1:0] LAST_IDX = PERM_AW'(PERM_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PASSES_W-1:0] passes_r;
  logic [DROP_W-1:0]   drop_r;
  logic                cfg_wr;
  reg_idx_t            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      passes_r <= PASSES_RST;
      drop_r   <= DROP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PASSES: passes_r <= pwdata[PASSES_W-1:0];
        REG_DROP:   drop_r   <= pwdata[DROP_W-1:0];
        default:    passes_r <= passes_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_PASSES: prdata = CFG_DW'(passes_r);
      REG_DROP:   prdata = CFG_DW'(drop_r);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t              state_r, state_nxt;
  logic [PERM_AW-1:0]  i_r, i_nxt;
  logic [PERM_AW-1:0]  j_r, j_nxt;
  logic [BYTE_W-1:0]   t_r, t_nxt;
  logic [BYTE_W-1:0]   ks_r, ks_nxt;
  logic [KIW-1:0]      kidx_r, kidx_nxt;
  logic [KLW-1:0]      key_len_r, key_len_nxt;
  logic [PASSES_W-1:0] pass_r, pass_nxt;
  logic [DROP_W-1:0]   drop_left_r, drop_left_nxt;
  logic                gen_out_r, gen_out_nxt;
  logic [BYTE_W-1:0]   value_r, value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;

  logic                in_fire;
  logic                out_free;
  logic                sched_done;
  logic                last_pass;
  logic                key_wr_en;
  logic [KLW-1:0]      len_eff;
  logic [BYTE_W-1:0]   key_rd_r;
  logic [BYTE_W-1:0]   j_sum;

  perm_wr_t            perm_wr;
  logic [PERM_AW-1:0]  perm_rd_addr;
  logic [BYTE_W-1:0]   perm_rd_data;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_free  = ~out_valid_r | out_ready;

  // empty key acts as one byte
  assign len_eff   = (key_len_r == '0) ? KLW'(1) : key_len_r;
  assign last_pass = ({1'b0, pass_r} + 9'd1) >= {1'b0, passes_r};

  // shared index adder: j + S[x], plus the key byte during the schedule
  assign j_sum = j_r + perm_rd_data + ((state_r == ST_KS_SW) ? key_rd_r : '0);

  // ---------------------------------------------------------------------------
  // Key store
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] key_mem [MAX_KEY_BYTES];

  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem[key_len_r[KIW-1:0]] <= in_value;
    end
    key_rd_r <= key_mem[kidx_r];
  end

  // ---------------------------------------------------------------------------
  // Permutation RAM
  // ---------------------------------------------------------------------------
  rc4d_perm_ram u_perm_ram (
    .clk     (clk),
    .wr      (perm_wr),
    .rd_addr (perm_rd_addr),
    .rd_data (perm_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    sched_done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_DATA) begin
            state_nxt = ST_GEN_RD;
          end else if (in_key_last) begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        if (i_r == LAST_IDX) begin
          if (passes_r == '0) begin
            sched_done = 1'b1;
          end else begin
            state_nxt = ST_KS_RD;
          end
        end
      end
      ST_KS_RD: state_nxt = ST_KS_SW;
      ST_KS_SW: state_nxt = ST_KS_W1;
      ST_KS_W1: state_nxt = ST_KS_W2;
      ST_KS_W2: begin
        if (i_r == LAST_IDX && last_pass) begin
          sched_done = 1'b1;
        end else begin
          state_nxt = ST_KS_RD;
        end
      end
      ST_GEN_RD: state_nxt = ST_GEN_SW;
      ST_GEN_SW: state_nxt = ST_GEN_W1;
      ST_GEN_W1: state_nxt = ST_GEN_W2;
      ST_GEN_W2: begin
        if (gen_out_r) begin
          if (out_free) begin
            state_nxt = ST_IDLE;
          end
        end else if (drop_left_r == DROP_W'(1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_GEN_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (sched_done) begin
      state_nxt = (drop_r != '0) ? ST_GEN_RD : ST_IDLE;
    end
  end

  // ---------------------------------------------------------------------------
  // RAM controls
  // ---------------------------------------------------------------------------
  always_comb begin
    perm_wr      = '{en: 1'b0, addr: i_r, data: i_r};
    perm_rd_addr = i_r;
    unique case (state_r)
      ST_FILL:   perm_wr = '{en: 1'b1, addr: i_r, data: i_r};
      ST_KS_SW:  perm_rd_addr = j_sum;
      ST_KS_W1:  perm_wr = '{en: 1'b1, addr: i_r, data: perm_rd_data};
      ST_KS_W2:  perm_wr = '{en: 1'b1, addr: j_r, data: t_r};
      ST_GEN_RD: perm_rd_addr = i_r + 8'd1;
      ST_GEN_SW: perm_rd_addr = j_sum;
      ST_GEN_W1: perm_wr = '{en: 1'b1, addr: i_r, data: perm_rd_data};
      ST_GEN_W2: perm_wr = '{en: 1'b1, addr: j_r, data: t_r};
      default:   perm_rd_addr = i_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    ks_nxt        = ks_r;
    kidx_nxt      = kidx_r;
    key_len_nxt   = key_len_r;
    pass_nxt      = pass_r;
    drop_left_nxt = drop_left_r;
    gen_out_nxt   = gen_out_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_byte_nxt  = out_byte_r;
    key_wr_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          value_nxt   = in_value;
          gen_out_nxt = (in_kind == KIND_DATA);
          if (in_kind == KIND_KEY) begin
            // bytes past the store size are dropped, length saturates
            if (key_len_r < MAX_LEN) begin
              key_wr_en   = 1'b1;
              key_len_nxt = key_len_r + KLW'(1);
            end
            if (in_key_last) begin
              i_nxt    = '0;
              j_nxt    = '0;
              kidx_nxt = '0;
              pass_nxt = '0;
            end
          end
        end
      end
      ST_FILL: i_nxt = i_r + 8'd1;
      ST_KS_SW: begin
        j_nxt = j_sum;
        t_nxt = perm_rd_data;
      end
      ST_KS_W2: begin
        i_nxt = i_r + 8'd1;
        if ((KLW'(kidx_r) + KLW'(1)) >= len_eff) begin
          kidx_nxt = '0;
        end else begin
          kidx_nxt = kidx_r + KIW'(1);
        end
        if (i_r == LAST_IDX) begin
          pass_nxt = pass_r + 8'd1;
        end
      end
      ST_GEN_RD: i_nxt = i_r + 8'd1;
      ST_GEN_SW: begin
        j_nxt = j_sum;
        t_nxt = perm_rd_data;
      end
      ST_GEN_W1: ks_nxt = t_r + perm_rd_data;
      ST_GEN_W2: begin
        if (gen_out_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = value_r ^ ks_r;
          end
        end else begin
          drop_left_nxt = drop_left_r - DROP_W'(1);
          if (drop_left_r == DROP_W'(1)) begin
            key_len_nxt = '0;
          end
        end
      end
      default: i_nxt = i_r;
    endcase
    // end of schedule: j restarts at zero, drop phase is loaded
    if (sched_done) begin
      j_nxt         = '0;
      drop_left_nxt = drop_r;
      if (drop_r == '0) begin
        key_len_nxt = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      kidx_r      <= '0;
      key_len_r   <= '0;
      pass_r      <= '0;
      drop_left_r <= '0;
      gen_out_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      kidx_r      <= kidx_nxt;
      key_len_r   <= key_len_nxt;
      pass_r      <= pass_nxt;
      drop_left_r <= drop_left_nxt;
      gen_out_r   <= gen_out_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    ks_r       <= ks_nxt;
    value_r    <= value_nxt;
    out_byte_r <= out_byte_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a new output word only comes from the last step of a data byte
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_GEN_W2 && gen_out_r))
    else $error("output word raised outside data step");

  // the drop phase never runs with an empty count
  a_drop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GEN_RD && !gen_out_r) |-> (drop_left_r != '0))
    else $error("drop step with zero count");

  // key length saturates at the store size
  a_key_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == KIND_KEY && !in_key_last && key_len_r == MAX_LEN)
      |=> (key_len_r == MAX_LEN))
    else $error("key length moved past store size");

endmodule
